[sv/lcsgd_pkg.sv]
// ----------------------------------------------------------------------------
// lcsgd_pkg
// shared types and constants of the online linear classifier trainer
// ----------------------------------------------------------------------------
`default_nettype none

package lcsgd_pkg;

    // configuration register indexes
    localparam logic CFG_LEARN_RATE = 1'b0;
    localparam logic CFG_DECAY      = 1'b1;

    // register reset values, unsigned q0.16, about 0.01
    localparam logic [15:0] LEARN_RATE_RESET = 16'd655;
    localparam logic [15:0] DECAY_RESET      = 16'd655;

    localparam int CFG_W      = 16;
    localparam int FEAT_FRAC  = 8;     // fraction bits of a feature
    localparam int Q_FRAC     = 16;    // fraction bits of weights and rates
    localparam int DECAY_W    = 33;    // decay term, signed
    localparam int OUT_DATA_W = 40;    // predicted_class + decision_value, byte padded

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD_A,
        ST_PROD_B,
        ST_DECIDE,
        ST_DECAY_A,
        ST_STEP_A,
        ST_DECAY_B,
        ST_STEP_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

endpackage

`default_nettype wire

[sv/lcsgd_mul.sv]
// ----------------------------------------------------------------------------
// lcsgd_mul
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lcsgd_mul #(
    parameter int MW = 34,
    parameter int BW = 17
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  lcsgd_pkg::mul_ctl_t     ctl,
    input  wire  [MW-1:0]           mcand,
    input  wire  [BW-1:0]           mlr,
    output lcsgd_pkg::mul_sts_t     sts,
    output logic [MW+BW:0]          product
);
    import lcsgd_pkg::*;

    localparam int CW = $clog2(BW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW:0]   acc_reg;
    logic [BW-1:0] mlr_reg;
    logic [MW-1:0] mcand_reg;

    logic          last;
    logic [MW:0]   addend;
    logic [MW:0]   sum;

    assign last = (cnt_reg == CW'(BW - 1));

    always_comb
    begin
        addend = mlr_reg[0] ? {mcand_reg[MW-1], mcand_reg} : '0;
        // the top multiplier bit carries negative weight
        sum    = last ? (acc_reg - addend) : (acc_reg + addend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg   <= '0;
            mlr_reg   <= mlr;
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum[MW], sum[MW:1]};
            mlr_reg <= {sum[0], mlr_reg[BW-1:1]};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = {acc_reg, mlr_reg};

endmodule

`default_nettype wire

[sv/linear_classifier_sgd_trainer.sv]
// ----------------------------------------------------------------------------
// linear_classifier_sgd_trainer
// online two-feature linear classifier with sgd-style training
// ----------------------------------------------------------------------------
// Each input transaction carries two signed q8.8 features, a label and a
// mode; each one yields exactly one output transaction with the decision
// value w0*a+w1*b+bias (signed q16.16, saturated) taken from the weights as
// they stood before the sample, the predicted class (1 when the value is not
// negative) and an updated flag. In train mode a margin violation applies
// weight decay plus a label step to both weights and a label step to the
// bias, all saturating. All products go through one bit-serial multiplier;
// each product is a launch, BW shift-add steps and a done strobe, where
// BW = max(SAMPLE_WIDTH,16)+1. A classify-only sample, or a training
// sample without a violation, needs two products; a training update adds
// four more products. One sample is in work at a time, since each one
// needs the weights the previous one left. The finished result sits in an
// output register, so the next sample is accepted while it still waits
// to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_classifier_sgd_trainer #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    // configuration write port
    input  wire                                     cfg_we,
    input  wire                                     cfg_addr,
    input  wire  [lcsgd_pkg::CFG_W-1:0]             cfg_data,
    // sample stream
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    // feature_a, feature_b, label, zero pad
    input  wire  [((2*SAMPLE_WIDTH+8)/8)*8-1:0]     s_tdata,
    // mode
    input  wire                                     s_tuser,
    // result stream
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    // predicted_class, decision_value, zero pad
    output logic [lcsgd_pkg::OUT_DATA_W-1:0]        m_tdata,
    // updated
    output logic                                    m_tuser
);
    import lcsgd_pkg::*;

    // multiplicand: weights and the step operand t = s*f*2^8 - decay
    localparam int MW    = (SAMPLE_WIDTH + 9 > 33) ? SAMPLE_WIDTH + 10 : 34;
    // multiplier: features or the zero-extended rates, always signed
    localparam int BW    = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;
    localparam int PW    = MW + BW + 1;
    // wide enough for the decision sum and every value before saturation
    localparam int ACC_W = SAMPLE_WIDTH + 27;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] learn_rate_reg;
    logic [CFG_W-1:0] decay_reg;

    // model state
    logic [31:0] weight_a_reg;
    logic [31:0] weight_b_reg;
    logic [31:0] offset_reg;

    // captured sample
    logic [SAMPLE_WIDTH-1:0] feat_a_reg;
    logic [SAMPLE_WIDTH-1:0] feat_b_reg;
    logic                    mode_reg;
    logic                    label_reg;

    // working values
    logic [ACC_W-1:0] acc_reg;
    logic [MW-1:0]    t_reg;
    logic [31:0]      dec_reg;
    logic             upd_reg;
    logic             launched_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [31:0]           out_dec_reg;
    logic                  out_class_reg;
    logic                  out_upd_reg;

    // multiplier
    mul_ctl_t        mul_ctl;
    mul_sts_t        mul_sts;
    logic [MW-1:0]   mcand_sel;
    logic [BW-1:0]   mlr_sel;
    logic [PW-1:0]   prod;

    logic                          in_take;
    logic                          out_free;
    logic [ACC_W-1:0]              prod_sh;
    logic [31:0]                   dec_sat;
    logic                          violate;
    logic [SAMPLE_WIDTH-1:0]       feat_cur;
    logic [SAMPLE_WIDTH:0]         sf;
    logic [DECAY_W-1:0]            decay;
    logic [MW-1:0]                 t_next;
    logic [31:0]                   w_cur;
    logic [ACC_W-1:0]              w_sum;
    logic [ACC_W-1:0]              b_sum;

    function automatic logic [31:0] sat32(input logic [ACC_W-1:0] v);
        logic [ACC_W-32:0] hi;
        hi = v[ACC_W-1:31];
        if ((&hi) || !(|hi))
            return v[31:0];
        else if (v[ACC_W-1])
            return SAT_MIN;
        else
            return SAT_MAX;
    endfunction

    lcsgd_mul #(
        .MW (MW),
        .BW (BW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .mcand   (mcand_sel),
        .mlr     (mlr_sel),
        .sts     (mul_sts),
        .product (prod)
    );

    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_PROD_A;
            end
            ST_PROD_A:
            begin
                if (mul_sts.done)
                    state_next = ST_PROD_B;
            end
            ST_PROD_B:
            begin
                if (mul_sts.done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // mode 0 trains; update only on a margin violation
                if (!mode_reg && violate)
                    state_next = ST_DECAY_A;
                else
                    state_next = ST_FINISH;
            end
            ST_DECAY_A:
            begin
                if (mul_sts.done)
                    state_next = ST_STEP_A;
            end
            ST_STEP_A:
            begin
                if (mul_sts.done)
                    state_next = ST_DECAY_B;
            end
            ST_DECAY_B:
            begin
                if (mul_sts.done)
                    state_next = ST_STEP_B;
            end
            ST_STEP_B:
            begin
                if (mul_sts.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: handshake, multiplier launch, operand select
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        mul_ctl.start = 1'b0;
        mcand_sel     = MW'($signed(weight_a_reg));
        mlr_sel       = BW'($signed(feat_a_reg));
        case (state_reg)
            ST_PROD_A:
            begin
                mul_ctl.start = !launched_reg && !mul_sts.busy;
                mcand_sel     = MW'($signed(weight_a_reg));
                mlr_sel       = BW'($signed(feat_a_reg));
            end
            ST_PROD_B:
            begin
                mul_ctl.start = !launched_reg && !mul_sts.busy;
                mcand_sel     = MW'($signed(weight_b_reg));
                mlr_sel       = BW'($signed(feat_b_reg));
            end
            ST_DECAY_A:
            begin
                mul_ctl.start = !launched_reg && !mul_sts.busy;
                mcand_sel     = MW'($signed(weight_a_reg));
                mlr_sel       = BW'(decay_reg);
            end
            ST_STEP_A:
            begin
                mul_ctl.start = !launched_reg && !mul_sts.busy;
                mcand_sel     = t_reg;
                mlr_sel       = BW'(learn_rate_reg);
            end
            ST_DECAY_B:
            begin
                mul_ctl.start = !launched_reg && !mul_sts.busy;
                mcand_sel     = MW'($signed(weight_b_reg));
                mlr_sel       = BW'(decay_reg);
            end
            ST_STEP_B:
            begin
                mul_ctl.start = !launched_reg && !mul_sts.busy;
                mcand_sel     = t_reg;
                mlr_sel       = BW'(learn_rate_reg);
            end
            default:
            begin
                mul_ctl.start = 1'b0;
            end
        endcase
    end

    // datapath arithmetic
    always_comb
    begin
        // product floored by 2^8: weight times feature back to q16.16
        prod_sh  = prod[FEAT_FRAC +: ACC_W];
        dec_sat  = sat32(acc_reg);
        // zero counts as a violation for both labels
        violate  = label_reg ? (dec_sat[31] || (dec_sat == '0)) : !dec_sat[31];
        feat_cur = (state_reg == ST_DECAY_A) ? feat_a_reg : feat_b_reg;
        sf       = label_reg ? (SAMPLE_WIDTH+1)'($signed(feat_cur))
                             : -(SAMPLE_WIDTH+1)'($signed(feat_cur));
        decay    = prod[Q_FRAC +: DECAY_W];
        t_next   = {(MW-FEAT_FRAC)'($signed(sf)), {FEAT_FRAC{1'b0}}}
                   - MW'($signed(decay));
        w_cur    = (state_reg == ST_STEP_A) ? weight_a_reg : weight_b_reg;
        w_sum    = ACC_W'($signed(w_cur)) + ACC_W'($signed(prod[Q_FRAC +: MW]));
        b_sum    = label_reg ? (ACC_W'($signed(offset_reg)) + ACC_W'(learn_rate_reg))
                             : (ACC_W'($signed(offset_reg)) - ACC_W'(learn_rate_reg));
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launched_reg   <= 1'b0;
            learn_rate_reg <= LEARN_RATE_RESET;
            decay_reg      <= DECAY_RESET;
            weight_a_reg   <= '0;
            weight_b_reg   <= '0;
            offset_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (mul_ctl.start)
                launched_reg <= 1'b1;
            else if (mul_sts.done)
                launched_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_LEARN_RATE: learn_rate_reg <= cfg_data;
                    CFG_DECAY:      decay_reg      <= cfg_data;
                    default:        learn_rate_reg <= learn_rate_reg;
                endcase
            end

            // weights change from their old values only
            if ((state_reg == ST_STEP_A) && mul_sts.done)
                weight_a_reg <= sat32(w_sum);
            if ((state_reg == ST_STEP_B) && mul_sts.done)
                weight_b_reg <= sat32(w_sum);

            if ((state_reg == ST_FINISH) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                if (upd_reg)
                    offset_reg <= sat32(b_sum);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            feat_a_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            feat_b_reg <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            label_reg  <= s_tdata[2*SAMPLE_WIDTH];
            mode_reg   <= s_tuser;
            upd_reg    <= 1'b0;
        end

        if ((state_reg == ST_PROD_A) && mul_sts.done)
            acc_reg <= prod_sh;
        if ((state_reg == ST_PROD_B) && mul_sts.done)
            acc_reg <= acc_reg + prod_sh + ACC_W'($signed(offset_reg));

        if (state_reg == ST_DECIDE)
        begin
            dec_reg <= dec_sat;
            upd_reg <= !mode_reg && violate;
        end

        if (((state_reg == ST_DECAY_A) || (state_reg == ST_DECAY_B)) && mul_sts.done)
            t_reg <= t_next;

        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_dec_reg   <= dec_reg;
            out_class_reg <= !dec_reg[31];
            out_upd_reg   <= upd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-33){1'b0}}, out_dec_reg, out_class_reg};
    assign m_tuser  = out_upd_reg;

endmodule

`default_nettype wire

[tb/lcsgd_checker.sv]
// ----------------------------------------------------------------------------
// lcsgd_checker
// watches the config port and both streams, predicts every result and
// compares it field by field with what the trainer puts out
// ----------------------------------------------------------------------------
module lcsgd_checker
    import lcsgd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [CFG_W-1:0]                    cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // feature_a, feature_b, label, zero pad
    input  logic [((2*SAMPLE_WIDTH+8)/8)*8-1:0] s_tdata,
    // mode
    input  logic                                s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // predicted_class, decision_value, zero pad
    input  logic [OUT_DATA_W-1:0]               m_tdata,
    // updated
    input  logic                                m_tuser,
    output int                                  failures,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_TOP = longint'($signed(SAT_MAX));
    localparam longint SAT_BOT = longint'($signed(SAT_MIN));

    typedef struct {
        logic               cls;
        logic signed [31:0] score;
        logic               upd;
    } verdict_t;

    verdict_t verdicts_due[$];

    // shadow of the trainer state and its two rate registers
    logic signed [31:0] wt_a, wt_b, bias;
    logic [CFG_W-1:0]   rate_q, decay_q;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > SAT_TOP)
            return SAT_MAX;
        if (v < SAT_BOT)
            return SAT_MIN;
        return v[31:0];
    endfunction

    // decay toward zero plus a label-driven pull along the feature
    function automatic logic signed [31:0] nudge_weight(input logic signed [31:0] w,
                                                       input longint f, input longint sgn);
        longint shrink, pull, stride;
        shrink = (longint'(decay_q) * longint'(w)) >>> Q_FRAC;
        pull   = sgn * f * (64'sd1 << (Q_FRAC - FEAT_FRAC)) - shrink;
        stride = (longint'(rate_q) * pull) >>> Q_FRAC;
        return clamp32(longint'(w) + stride);
    endfunction

    function automatic verdict_t score_sample(input logic classify, input longint fa,
                                              input longint fb, input logic label);
        verdict_t           v;
        longint             sgn, sum;
        logic signed [31:0] na, nb;
        logic               hit;
        sgn = label ? 64'sd1 : -64'sd1;
        sum = ((longint'(wt_a) * fa) >>> FEAT_FRAC) + ((longint'(wt_b) * fb) >>> FEAT_FRAC)
            + longint'(bias);
        v.score = clamp32(sum);
        v.cls   = (v.score >= 0);
        v.upd   = 1'b0;
        // zero decision violates the margin for either label
        hit = label ? (v.score <= 0) : (v.score >= 0);
        if (!classify && hit) begin
            na   = nudge_weight(wt_a, fa, sgn);
            nb   = nudge_weight(wt_b, fb, sgn);
            wt_a = na;
            wt_b = nb;
            bias = clamp32(longint'(bias) + sgn * longint'(rate_q));
            v.upd = 1'b1;
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
        failures++;
        if (failures <= 100)
            $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        verdict_t fresh, seen, due;
        if (!rst_n) begin
            wt_a     = '0;
            wt_b     = '0;
            bias     = '0;
            rate_q   = LEARN_RATE_RESET;
            decay_q  = DECAY_RESET;
            failures = 0;
            verdicts_due.delete();
            pending <= 0;
        end else begin
            // results first, so a stray one never pairs with this edge's sample
            if (m_tvalid && m_tready) begin
                seen.cls   = m_tdata[0];
                seen.score = m_tdata[32:1];
                seen.upd   = m_tuser;
                if (verdicts_due.size() == 0) begin
                    flag_mismatch("result with nothing pending", seen.score, 0);
                end else begin
                    due = verdicts_due.pop_front();
                    if (seen.cls !== due.cls)
                        flag_mismatch("predicted_class", seen.cls, due.cls);
                    if (seen.score !== due.score)
                        flag_mismatch("decision_value", seen.score, due.score);
                    if (seen.upd !== due.upd)
                        flag_mismatch("updated", seen.upd, due.upd);
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = score_sample(s_tuser, $signed(s_tdata[SAMPLE_WIDTH-1:0]),
                                     $signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
                                     s_tdata[2*SAMPLE_WIDTH]);
                verdicts_due.insert(verdicts_due.size(), fresh);
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_LEARN_RATE: rate_q  = cfg_data;
                    CFG_DECAY:      decay_q = cfg_data;
                    default:        rate_q  = rate_q;
                endcase
            end
            pending <= verdicts_due.size();
        end
    end

endmodule

[tb/tb_linear_classifier_sgd_trainer.sv]
// ----------------------------------------------------------------------------
// tb_linear_classifier_sgd_trainer
// stimulus and verdict for the online linear classifier trainer
// ----------------------------------------------------------------------------
// A directed run covers zero decisions, full-scale features, decision
// saturation both ways, classify-only samples and the rate extremes. Then
// several random phases follow, each under its own pair of rates, with
// labels mostly drawn from a hidden separating line so the weights settle
// and both violating and clean samples keep coming. Both stream sides idle
// at random; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_linear_classifier_sgd_trainer;
    timeunit 1ns;
    timeprecision 1ps;

    import lcsgd_pkg::*;

    localparam int SW         = 16;
    localparam int IN_W       = ((2*SW+8)/8)*8;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 150;
    localparam int TAIL_WAIT  = 120;   // a bit more than a full training update

    // sample mode and label codes
    localparam logic MODE_TRAIN    = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;
    localparam logic LABEL_NEG     = 1'b0;
    localparam logic LABEL_POS     = 1'b1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_addr;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic              m_tuser;

    int failures;
    int pending;

    // stretches without idling on either side
    bit tx_eager;
    bit rx_eager;
    int rx_wait;

    // hidden separating line of the current random phase
    int teach_a;
    int teach_b;

    always #4 clk = ~clk;

    linear_classifier_sgd_trainer #(
        .SAMPLE_WIDTH (SW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lcsgd_checker #(
        .SAMPLE_WIDTH (SW)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .failures (failures),
        .pending  (pending)
    );

    // result side: after a transaction, unless eager, mostly hold ready low for a random stall
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else if (m_tvalid && m_tready) begin
            if (!rx_eager && $urandom_range(0, 8) != 0) begin
                rx_wait  <= $urandom_range(1, 8);
                m_tready <= 1'b0;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one sample after a random gap; valid stays high when no gap follows
    task automatic push_sample(input logic mode, input int fa, input int fb,
                               input logic label);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_W'({label, fb[SW-1:0], fa[SW-1:0]});
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both rate registers in back-to-back writes, only while idle
    task automatic set_rates(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] decay);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_LEARN_RATE;
        cfg_data <= rate;
        @(posedge clk);
        cfg_addr <= CFG_DECAY;
        cfg_data <= decay;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return LEARN_RATE_RESET;
            3:       return CFG_W'($urandom_range(1, 255));
            4:       return CFG_W'($urandom_range(256, 8191));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // mix of full-scale extremes, small values and full-range noise
    function automatic int draw_feature();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return -(1 << (SW-1));
                    1:       return (1 << (SW-1)) - 1;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 1023) - 512;
            default: return $urandom_range(0, (1 << SW) - 1) - (1 << (SW-1));
        endcase
    endfunction

    task automatic random_sample();
        int   fa, fb;
        logic mode, label;
        fa   = draw_feature();
        fb   = draw_feature();
        mode = ($urandom_range(0, 3) == 0) ? MODE_CLASSIFY : MODE_TRAIN;
        // mostly consistent with the hidden line, the rest is label noise
        if ($urandom_range(0, 9) < 6)
            label = (teach_a * fa + teach_b * fb >= 0) ? LABEL_POS : LABEL_NEG;
        else
            label = 1'($urandom_range(0, 1));
        push_sample(mode, fa, fb, label);
    endtask

    task automatic run_phase(input int count, input bit hold_midway);
        int k;
        teach_a = $urandom_range(0, 16) - 8;
        teach_b = $urandom_range(0, 16) - 8;
        for (k = 0; k < count; k++) begin
            if (k % 25 == 0) begin
                tx_eager = ($urandom_range(0, 3) == 0);
                rx_eager <= ($urandom_range(0, 3) == 0);
            end
            // sender holds off until the block has drained
            if (hold_midway && k == count / 2)
                settle();
            random_sample();
        end
    endtask

    initial begin
        int ph;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_addr <= CFG_LEARN_RATE;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_TRAIN;
        tx_eager = 1'b0;
        rx_eager <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rates: zero decision in both labels, full-scale features
        push_sample(MODE_CLASSIFY, 0, 0, LABEL_POS);
        push_sample(MODE_TRAIN, 32767, -32768, LABEL_POS);
        push_sample(MODE_TRAIN, -32768, 32767, LABEL_NEG);
        push_sample(MODE_CLASSIFY, -1, 1, LABEL_NEG);
        push_sample(MODE_TRAIN, 0, 0, LABEL_NEG);
        push_sample(MODE_TRAIN, 1, -1, LABEL_POS);

        // full step, no decay: weights jump far enough to saturate the decision
        settle();
        set_rates('1, '0);
        push_sample(MODE_TRAIN, 32767, 32767, LABEL_POS);
        push_sample(MODE_TRAIN, 32767, 32767, LABEL_POS);
        push_sample(MODE_CLASSIFY, 32767, 32767, LABEL_NEG);
        push_sample(MODE_CLASSIFY, -32768, -32768, LABEL_POS);
        push_sample(MODE_TRAIN, -32768, -32768, LABEL_POS);
        push_sample(MODE_TRAIN, 32767, 32767, LABEL_NEG);
        push_sample(MODE_TRAIN, 32767, -32768, LABEL_NEG);

        // zero step: violations still flag an update but nothing moves
        settle();
        set_rates('0, '1);
        push_sample(MODE_TRAIN, 16384, -16384, LABEL_POS);
        push_sample(MODE_TRAIN, -256, 256, LABEL_NEG);
        push_sample(MODE_CLASSIFY, 255, -255, LABEL_POS);

        // both rates at full scale
        settle();
        set_rates('1, '1);
        push_sample(MODE_TRAIN, 32767, 0, LABEL_NEG);
        push_sample(MODE_TRAIN, 0, -32768, LABEL_POS);
        push_sample(MODE_TRAIN, -32768, 32767, LABEL_POS);
        push_sample(MODE_CLASSIFY, 32767, -32768, LABEL_NEG);

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            set_rates(pick_rate(), pick_rate());
            run_phase(PHASE_LEN, ph == 2);
        end

        settle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, roughly ten times the slowest legal run
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
